// ===== sv/siphash_2_4_engine_macros.svh =====
// Assertion helpers for the keyed hash engine.
`ifndef SIPHASH_2_4_ENGINE_MACROS_SVH
`define SIPHASH_2_4_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF
`define SIPH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SIPH_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SIPH_ASSERT(lbl, clk, rst, prop, msg)
`define SIPH_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== sv/siph_pkg.sv =====
`default_nettype none
package siph_pkg;

   localparam int WORD_W         = 64;
   localparam int BYTES_PER_WORD = 8;
   localparam int COUNT_W        = 4;
   localparam int LEN_W          = 8;
   localparam int CSR_INDEX_W    = 1;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [3:0]    chain_type;

   localparam word_type SIP_C0  = 64'h736f6d6570736575;
   localparam word_type SIP_C1  = 64'h646f72616e646f6d;
   localparam word_type SIP_C2  = 64'h6c7967656e657261;
   localparam word_type SIP_C3  = 64'h7465646279746573;
   localparam word_type SIP_FIN = 64'h00000000000000ff;

   localparam logic [CSR_INDEX_W-1:0] REG_KEY_LOW  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_HIGH = 1'b1;

   localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

   typedef enum logic [1:0] {
      KIND_WORD,
      KIND_LAST_SHORT,
      KIND_LAST_FULL
   } kind_type;

   typedef struct packed {
      kind_type kind;
      word_type word;
      word_type block;
   } q_entry_type;

   typedef enum logic [1:0] {
      ST_ABSORB,
      ST_SECOND,
      ST_FIN1,
      ST_FIN2
   } back_state_type;

   function automatic word_type rotl(word_type x, int unsigned n);
      return (x << n) | (x >> (WORD_W - n));
   endfunction

   function automatic chain_type sip_round(chain_type v);
      word_type a, b, c, d;
      a = v[0];
      b = v[1];
      c = v[2];
      d = v[3];
      a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
      c = c + d; d = rotl(d, 16); d = d ^ c;
      a = a + d; d = rotl(d, 21); d = d ^ a;
      c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
      return {d, c, b, a};
   endfunction

   function automatic chain_type init_chain(word_type k0, word_type k1);
      return {SIP_C3 ^ k1, SIP_C2 ^ k0, SIP_C1 ^ k1, SIP_C0 ^ k0};
   endfunction

endpackage
`default_nettype wire

// ===== sv/siph_front.sv =====
`default_nettype none
module siph_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire siph_pkg::word_type    req_data_word,
   input  wire logic [3:0]            req_byte_count,
   input  wire logic                  req_is_last,
   input  wire logic                  csr_we,
   input  wire logic                  q_full,
   output      logic                  q_push,
   output      siph_pkg::q_entry_type q_entry
);
   import siph_pkg::*;

   logic [LEN_W-1:0]          length_ff, length_in;
   logic [COUNT_W-1:0]        count_sat;
   logic [LEN_W-1:0]          len_plus8, len_plus_cnt;
   word_type                  masked;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      count_sat    = (req_byte_count > FULL_COUNT) ? FULL_COUNT : req_byte_count;
      len_plus8    = length_ff + LEN_W'(BYTES_PER_WORD);
      len_plus_cnt = length_ff + LEN_W'(count_sat);
      for (int b = 0; b < BYTES_PER_WORD; b++) begin
         masked[b*8 +: 8] = (COUNT_W'(b) < count_sat) ? req_data_word[b*8 +: 8] : 8'd0;
      end
   end

   always_comb begin
      q_entry.word  = req_data_word;
      q_entry.block = req_data_word;
      if (!req_is_last) begin
         q_entry.kind = KIND_WORD;
      end else if (count_sat == FULL_COUNT) begin
         q_entry.kind  = KIND_LAST_FULL;
         q_entry.block = {len_plus8, {(WORD_W-LEN_W){1'b0}}};
      end else begin
         q_entry.kind  = KIND_LAST_SHORT;
         q_entry.block = {len_plus_cnt, masked[WORD_W-LEN_W-1:0]};
         q_entry.word  = q_entry.block;
      end
   end

   always_comb begin
      length_in = length_ff;
      priority if (csr_we) begin
         length_in = '0;
      end else if (q_push && req_is_last) begin
         length_in = '0;
      end else if (q_push) begin
         length_in = len_plus8;
      end else begin
         length_in = length_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else begin
         length_ff <= length_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/siph_queue.sv =====
`default_nettype none
`include "siphash_2_4_engine_macros.svh"
module siph_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire siph_pkg::q_entry_type push_entry,
   output      logic                  full,
   input  wire logic                  pop,
   output      logic                  head_valid,
   output      siph_pkg::q_entry_type head_entry
);
   import siph_pkg::*;

   q_entry_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]      count_ff, count_in;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `SIPH_ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && !head_valid, "pop from empty queue")
   `SIPH_ASSERT_NEVER(a_no_push_full, clock, reset, push && full, "push into full queue")

endmodule
`default_nettype wire

// ===== sv/siph_back.sv =====
`default_nettype none
`include "siphash_2_4_engine_macros.svh"
module siph_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [siph_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire siph_pkg::word_type                  csr_wdata,
   input  wire logic                                head_valid,
   input  wire siph_pkg::q_entry_type               head_entry,
   output      logic                                pop,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      siph_pkg::word_type                  rsp_hash_value
);
   import siph_pkg::*;

   back_state_type state_ff, state_in;
   chain_type      chain_ff, chain_in;
   word_type       key_low_ff, key_low_in;
   word_type       key_high_ff, key_high_in;
   word_type       block_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   word_type       hash_ff;

   logic           slot_free;
   logic           absorb_en, fin_en, step_en, hash_load;
   word_type       msg;
   chain_type      pre, rounds;

   assign slot_free      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = hash_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ABSORB: begin
            if (head_valid) begin
               unique case (head_entry.kind)
                  KIND_LAST_FULL:  state_in = ST_SECOND;
                  KIND_LAST_SHORT: state_in = ST_FIN1;
                  default:         state_in = ST_ABSORB;
               endcase
            end
         end
         ST_SECOND: state_in = ST_FIN1;
         ST_FIN1:   state_in = ST_FIN2;
         ST_FIN2: begin
            if (slot_free) begin
               state_in = ST_ABSORB;
            end
         end
         default:   state_in = ST_ABSORB;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      absorb_en = 1'b0;
      fin_en    = 1'b0;
      step_en   = 1'b0;
      hash_load = 1'b0;
      msg       = block_ff;
      unique case (state_ff)
         ST_ABSORB: begin
            pop       = head_valid;
            absorb_en = head_valid;
            step_en   = head_valid;
            msg       = head_entry.word;
         end
         ST_SECOND: begin
            absorb_en = 1'b1;
            step_en   = 1'b1;
         end
         ST_FIN1: begin
            fin_en  = 1'b1;
            step_en = 1'b1;
         end
         ST_FIN2: begin
            hash_load = slot_free;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      pre = chain_ff;
      if (absorb_en) begin
         pre[3] = chain_ff[3] ^ msg;
      end
      if (fin_en) begin
         pre[2] = chain_ff[2] ^ SIP_FIN;
      end
      rounds = sip_round(sip_round(pre));
      if (absorb_en) begin
         rounds[0] = rounds[0] ^ msg;
      end
   end

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_we && csr_index == REG_KEY_LOW) begin
         key_low_in = csr_wdata;
      end
      if (csr_we && csr_index == REG_KEY_HIGH) begin
         key_high_in = csr_wdata;
      end
      chain_in = chain_ff;
      priority if (csr_we) begin
         chain_in = init_chain(key_low_in, key_high_in);
      end else if (hash_load) begin
         chain_in = init_chain(key_low_ff, key_high_ff);
      end else if (step_en) begin
         chain_in = rounds;
      end else begin
         chain_in = chain_ff;
      end
      rsp_valid_in = rsp_valid_ff;
      if (hash_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ABSORB;
         key_low_ff   <= '0;
         key_high_ff  <= '0;
         chain_ff     <= init_chain('0, '0);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_low_ff   <= key_low_in;
         key_high_ff  <= key_high_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         block_ff <= head_entry.block;
      end
      if (hash_load) begin
         hash_ff <= rounds[0] ^ rounds[1] ^ rounds[2] ^ rounds[3];
      end
   end

   `SIPH_ASSERT(a_rsp_from_fin, clock, reset,
                $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN2),
                "result raised outside final step")
   `SIPH_ASSERT(a_reinit_after_hash, clock, reset,
                (hash_load && !csr_we) |=>
                   (chain_ff == init_chain(key_low_ff, key_high_ff)),
                "chain not reinitialized after hash")

endmodule
`default_nettype wire

// ===== sv/siphash_2_4_engine.sv =====
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_data_word, req_byte_count, req_is_last
// rsp       out        rsp_valid/rsp_ready    rsp_hash_value
// csr       in         csr_we (no wait)       csr_index, csr_wdata
//
// A non-last word passes the compression unit (two SipRounds): one word per cycle, except while a last item finishes.
// A last item steps through ST_ABSORB, ST_SECOND (eight bytes only), ST_FIN1 and ST_FIN2 before the result.
// A two-entry queue sits between classification and compression; req_ready drops only when full.
// rsp holds its result until taken; the final step waits while the result register is occupied.
// Reset is synchronous; the chain starts from the init constants with a zero key.
`default_nettype none
module siphash_2_4_engine (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [63:0]                         req_data_word,
   input  wire logic [3:0]                          req_byte_count,
   input  wire logic                                req_is_last,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [63:0]                         rsp_hash_value,
   input  wire logic                                csr_we,
   input  wire logic [siph_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [63:0]                         csr_wdata
);
   import siph_pkg::*;

   logic        q_full, q_push, q_pop, q_head_valid;
   q_entry_type q_push_entry, q_head_entry;

   siph_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_is_last    (req_is_last),
      .csr_we         (csr_we),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (q_push_entry)
   );

   siph_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   siph_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .head_valid     (q_head_valid),
      .head_entry     (q_head_entry),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule
`default_nettype wire

// ===== tb/siphash_2_4_engine_checker.sv =====
`default_nettype none
module siphash_2_4_engine_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_ready,
   input  wire logic [63:0]                      req_data_word,
   input  wire logic [3:0]                       req_byte_count,
   input  wire logic                             req_is_last,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   input  wire logic [63:0]                      rsp_hash_value,
   input  wire logic                             csr_we,
   input  wire logic [siph_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [63:0]                      csr_wdata,
   output int                                    hash_errors,
   output int                                    hashes_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   import siph_pkg::*;

   word_type       key_k0;
   word_type       key_k1;
   word_type       v0, v1, v2, v3;
   logic [7:0]     byte_total;
   word_type       hash_due_q[$];

   function automatic word_type rol64(word_type x, int unsigned n);
      return (x << n) | (x >> (64 - n));
   endfunction

   task automatic mix_round;
      v0 = v0 + v1; v1 = rol64(v1, 13); v1 = v1 ^ v0; v0 = rol64(v0, 32);
      v2 = v2 + v3; v3 = rol64(v3, 16); v3 = v3 ^ v2;
      v0 = v0 + v3; v3 = rol64(v3, 21); v3 = v3 ^ v0;
      v2 = v2 + v1; v1 = rol64(v1, 17); v1 = v1 ^ v2; v2 = rol64(v2, 32);
   endtask

   task automatic compress(input word_type m);
      v3 = v3 ^ m;
      mix_round();
      mix_round();
      v0 = v0 ^ m;
   endtask

   task automatic restart_chain;
      v0 = SIP_C0 ^ key_k0;
      v1 = SIP_C1 ^ key_k1;
      v2 = SIP_C2 ^ key_k0;
      v3 = SIP_C3 ^ key_k1;
      byte_total = 8'd0;
   endtask

   task automatic predict_beat(input word_type w, input logic [3:0] cnt, input logic last);
      int unsigned nbytes;
      word_type    tail;
      word_type    mask;
      if (!last) begin
         compress(w);
         byte_total = byte_total + 8'd8;
      end else begin
         nbytes = (cnt > 4'd8) ? 8 : cnt;
         if (nbytes == 8) begin
            compress(w);
            byte_total = byte_total + 8'd8;
            tail = {byte_total, 56'h0};
         end else begin
            mask = (64'h1 << (8 * nbytes)) - 64'h1;
            byte_total = byte_total + 8'(nbytes);
            tail = (w & mask) | {byte_total, 56'h0};
         end
         compress(tail);
         v2 = v2 ^ SIP_FIN;
         repeat (4) mix_round();
         hash_due_q.push_back(v0 ^ v1 ^ v2 ^ v3);
         restart_chain();
      end
   endtask

   always @(posedge clock) begin
      word_type want;
      if (reset) begin
         key_k0 = '0;
         key_k1 = '0;
         restart_chain();
         hash_due_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (hash_due_q.size() == 0) begin
               $display("%0t: unexpected hash beat, expected none, actual %h",
                        $time, rsp_hash_value);
               hash_errors = hash_errors + 1;
            end else begin
               want = hash_due_q.pop_front();
               if (rsp_hash_value !== want) begin
                  $display("%0t: hash_value mismatch, expected %h, actual %h",
                           $time, want, rsp_hash_value);
                  hash_errors = hash_errors + 1;
               end
            end
         end
         if (csr_we) begin
            if (csr_index == REG_KEY_LOW) begin
               key_k0 = csr_wdata;
            end else begin
               key_k1 = csr_wdata;
            end
            restart_chain();
         end
         if (req_valid && req_ready) begin
            predict_beat(req_data_word, req_byte_count, req_is_last);
         end
      end
      hashes_owed = hash_due_q.size();
   end

endmodule
`default_nettype wire

// ===== tb/tb_siphash_2_4_engine.sv =====
`default_nettype none
module tb_siphash_2_4_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import siph_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [63:0]            req_data_word;
   logic [3:0]             req_byte_count;
   logic                   req_is_last;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [63:0]            rsp_hash_value;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [63:0]            csr_wdata;

   int          hash_errors;
   int          hashes_owed;
   int          hold_requests = 0;
   int unsigned burst_left;
   bit          gaps_on;

   siphash_2_4_engine u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   siphash_2_4_engine_checker u_hash_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .hash_errors    (hash_errors),
      .hashes_owed    (hashes_owed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(2_000_000);
      $display("[siphash_2_4_engine] ERROR");
      $finish;
   end

   // receiver: changes stall style at random, long hold-off on request
   initial begin
      int unsigned holds_done;
      int unsigned style;
      int unsigned tick;
      rsp_ready = 1'b0;
      holds_done = 0;
      style = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (200) @(negedge clock);
         end else begin
            if (tick % 48 == 0) style = $urandom_range(0, 3);
            tick++;
            case (style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= tick[2];
            endcase
         end
      end
   end

   function automatic word_type rand_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic pause(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic send_beat(input word_type w, input logic [3:0] cnt, input logic last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gaps_on && $urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_data_word  <= w;
      req_byte_count <= cnt;
      req_is_last    <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_message(output int beats);
      int unsigned words;
      int unsigned cnt;
      words = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 4);
      cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      for (int i = 0; i < words; i++) send_beat(rand_word(), 4'($urandom), 1'b0);
      send_beat(rand_word(), 4'(cnt), 1'b1);
      beats = words + 1;
   endtask

   // drain all hashes, then let queued words finish compressing
   task automatic settle;
      pause(1);
      while (hashes_owed != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_key(input logic [CSR_INDEX_W-1:0] idx, input word_type val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      word_type phase_k0[5];
      word_type phase_k1[5];
      int       sent;
      int       beats;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_word  = '0;
      req_byte_count = '0;
      req_is_last    = 1'b0;
      csr_we         = 1'b0;
      csr_index      = REG_KEY_LOW;
      csr_wdata      = '0;
      burst_left     = 0;
      gaps_on        = 1'b1;
      phase_k0[0] = 64'h0706050403020100;
      phase_k1[0] = 64'h0f0e0d0c0b0a0908;
      phase_k0[1] = '1;
      phase_k1[1] = '1;
      phase_k0[2] = '0;
      phase_k1[2] = '1;
      phase_k0[3] = {$urandom, $urandom};
      phase_k1[3] = {$urandom, $urandom};
      phase_k0[4] = {$urandom, $urandom};
      phase_k1[4] = {$urandom, $urandom};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty message, full last word, oversized counts
      send_beat('1, 4'd0, 1'b1);
      send_beat('1, FULL_COUNT, 1'b1);
      send_beat('0, 4'd15, 1'b1);
      send_beat('1, 4'd9, 1'b1);
      // non-last ignores byte_count
      send_beat('0, 4'd15, 1'b0);
      send_beat('1, 4'd1, 1'b1);
      send_beat('1, 4'd0, 1'b0);
      send_beat(64'h0706050403020100, 4'd3, 1'b0);
      send_beat('1, 4'd7, 1'b1);
      send_beat(rand_word(), 4'd4, 1'b1);
      send_beat(64'h5555555555555555, FULL_COUNT, 1'b0);
      send_beat(64'haaaaaaaaaaaaaaaa, 4'd2, 1'b1);
      // leave a partial message for the key write to drop
      send_beat(rand_word(), 4'd8, 1'b0);
      send_beat(rand_word(), 4'd5, 1'b0);

      for (int p = 0; p < 5; p++) begin
         settle();
         if (p != 3) write_key(REG_KEY_LOW, phase_k0[p]);
         write_key(REG_KEY_HIGH, phase_k1[p]);
         if (p == 1) hold_requests <= hold_requests + 1;
         gaps_on = (p != 2);
         sent = 0;
         while (sent < 130) begin
            send_message(beats);
            sent += beats;
         end
         if (p == 2) begin
            for (int i = 0; i < 3; i++) send_beat(rand_word(), 4'($urandom), 1'b0);
         end
      end

      settle();
      if (hash_errors == 0) begin
         $display("[siphash_2_4_engine] OK");
      end else begin
         $display("[siphash_2_4_engine] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/siph_pkg.sv
sv/siph_front.sv
sv/siph_queue.sv
sv/siph_back.sv
sv/siphash_2_4_engine.sv
tb/siphash_2_4_engine_checker.sv
tb/tb_siphash_2_4_engine.sv
